### hdl/tcis_pkg.sv
// Shared constants, types and the control store for the instruction-step core.
package tcis_pkg;

	// Byte memory geometry: four byte-wide banks, one word row across them
	localparam int unsigned MEM_BYTES = 65536;
	localparam int unsigned AW        = $clog2(MEM_BYTES);
	localparam int unsigned ROWS      = MEM_BYTES / 4;
	localparam int unsigned RW        = AW - 2;

	// Configuration port
	localparam int unsigned PAW = 3;
	localparam logic [PAW-3:0] REG_START_PC = '0;

	// Item kinds
	localparam logic [1:0] KIND_WBYTE   = 2'd0;
	localparam logic [1:0] KIND_EXEC    = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	// Opcodes
	localparam logic [7:0] OP_MOV   = 8'd1;
	localparam logic [7:0] OP_ADD   = 8'd2;
	localparam logic [7:0] OP_SUB   = 8'd3;
	localparam logic [7:0] OP_CMP   = 8'd4;
	localparam logic [7:0] OP_JMP   = 8'd5;
	localparam logic [7:0] OP_JE    = 8'd6;
	localparam logic [7:0] OP_JNE   = 8'd7;
	localparam logic [7:0] OP_LOAD  = 8'd8;
	localparam logic [7:0] OP_STORE = 8'd9;
	localparam logic [7:0] OP_HLT   = 8'd10;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FETCH,
		S_DECODE,
		S_ALU,
		S_JUMP,
		S_LOAD0,
		S_LOAD1,
		S_STORE,
		S_HALT,
		S_WBYTE,
		S_RESTART,
		S_DONE,
		S_CLEAR
	} step_t;

	typedef enum logic [2:0] {
		M_NONE,
		M_RD_PC,
		M_RD_PC4,
		M_RD_A,
		M_WR_BYTE,
		M_WR_WORD,
		M_WR_CLR
	} mem_op_t;

	typedef enum logic [2:0] {
		SQ_GOTO,
		SQ_KIND,
		SQ_OPC,
		SQ_WAIT_OUT,
		SQ_CLEAR
	} seq_t;

	typedef struct packed {
		mem_op_t mem;
		logic    sel_rd;
		logic    ld_ir;
		logic    ld_imm;
		logic    ld_a;
		logic    pc_inc;
		logic    alu;
		logic    jump;
		logic    ld_load;
		logic    store;
		logic    halt;
		logic    restart;
		seq_t    seq;
		step_t   target;
	} uc_t;

	// Control store: one word per step
	function automatic uc_t uc_rom(step_t s);
		uc_t u;
		u = '0;
		u.seq = SQ_GOTO;
		u.target = S_DONE;
		unique case (s)
			S_IDLE: begin
				u.mem = M_RD_PC;
				u.seq = SQ_KIND;
			end
			S_FETCH: begin
				u.ld_ir = 1'b1;
				u.mem = M_RD_PC4;
				u.target = S_DECODE;
			end
			S_DECODE: begin
				u.ld_imm = 1'b1;
				u.ld_a = 1'b1;
				u.pc_inc = 1'b1;
				u.seq = SQ_OPC;
			end
			S_ALU: begin
				u.sel_rd = 1'b1;
				u.alu = 1'b1;
			end
			S_JUMP:  u.jump = 1'b1;
			S_LOAD0: begin
				u.mem = M_RD_A;
				u.target = S_LOAD1;
			end
			S_LOAD1: u.ld_load = 1'b1;
			S_STORE: begin
				u.sel_rd = 1'b1;
				u.mem = M_WR_WORD;
				u.store = 1'b1;
			end
			S_HALT:    u.halt = 1'b1;
			S_WBYTE:   u.mem = M_WR_BYTE;
			S_RESTART: u.restart = 1'b1;
			S_DONE: begin
				u.sel_rd = 1'b1;
				u.seq = SQ_WAIT_OUT;
				u.target = S_IDLE;
			end
			S_CLEAR: begin
				u.mem = M_WR_CLR;
				u.seq = SQ_CLEAR;
				u.target = S_IDLE;
			end
			default: u.target = S_IDLE;
		endcase
		return u;
	endfunction

endpackage

### hdl/tcis_mem.sv
// Banked byte memory with an unaligned little-endian word read and write port.
module tcis_mem import tcis_pkg::*; (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	input  logic [3:0]    wr_be
);

	logic [RW-1:0] rd_row, wr_row;
	logic [1:0]    rd_off, wr_off;
	logic [1:0]    rd_off_q;
	logic [7:0]    bank_rd [4];

	assign rd_row = rd_addr[AW-1:2];
	assign rd_off = rd_addr[1:0];
	assign wr_row = wr_addr[AW-1:2];
	assign wr_off = wr_addr[1:0];

	// Byte i of a word at address a lives in bank (a+i)%4; banks below the
	// start offset take the next row, which wraps at the top of memory.
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [7:0]    mem_q [ROWS];
		logic [7:0]    rd_q;
		logic [1:0]    wi;
		logic [RW-1:0] wrow, rrow;

		assign wi   = 2'(b) - wr_off;
		assign wrow = (2'(b) >= wr_off) ? wr_row : wr_row + RW'(1);
		assign rrow = (2'(b) >= rd_off) ? rd_row : rd_row + RW'(1);

		always_ff @(posedge clk) begin
			if (wr_en && wr_be[wi]) begin
				mem_q[wrow] <= wr_data[8*wi +: 8];
			end
			rd_q <= mem_q[rrow];
		end

		assign bank_rd[b] = rd_q;
	end

	always_ff @(posedge clk) begin
		rd_off_q <= rd_off;
	end

	always_comb begin
		logic [1:0] idx;
		for (int i = 0; i < 4; i++) begin
			idx = rd_off_q + 2'(i);
			rd_data[8*i +: 8] = bank_rd[idx];
		end
	end

endmodule

### hdl/tiny_cpu_instruction_step.sv
// Top level: microcoded sequencer, register file and datapath of the core.
//
//  channel  dir  handshake              payload
//  in       in   in_valid / in_ready    kind, load_addr, load_byte
//  out      out  out_valid / out_ready  pc, flag, running, dest_value,
//                                       store_valid, store_addr, store_data
//  cfg      in   APB psel/penable/...   start_pc at byte address 0
//
// Steps per item, from the accepting step to DONE, which raises out_valid: a halted
// execute or unknown kind goes straight there; byte write and restart via WBYTE or
// RESTART; execute via FETCH, DECODE, then ALU, JUMP, STORE, HALT or LOAD0+LOAD1,
// or none for NOP. The single word read port gives fetch two reads and load a third.
// After reset a clearing pass writes zero to all MEM_BYTES/4 memory rows (16384),
// with in_ready low. A waiting result holds the next item in its final step.
module tiny_cpu_instruction_step import tcis_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	// input items
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     kind,
	input  logic [15:0]    load_addr,
	input  logic [7:0]     load_byte,
	// result items
	output logic           out_valid,
	input  logic           out_ready,
	output logic [15:0]    pc,
	output logic           flag,
	output logic           running,
	output logic [31:0]    dest_value,
	output logic           store_valid,
	output logic [15:0]    store_addr,
	output logic [31:0]    store_data,
	// configuration
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [PAW-1:0] paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	uc_t uc;

	step_t         step_q, step_d;
	logic [AW-1:0] pc_q;
	logic          flag_q, run_q, exec_q, out_valid_q;
	logic [RW-1:0] clr_q;
	logic [15:0]   start_pc_q;

	logic [7:0]    op_q;
	logic [2:0]    rd_q, rs_q;
	logic          mode_q;
	logic [31:0]   imm_q, a_q;
	logic [AW-1:0] la_q;
	logic [7:0]    lb_q;
	logic          st_valid_q;
	logic [AW-1:0] st_addr_q;
	logic [31:0]   st_data_q;

	logic [15:0]   res_pc_q, res_st_addr_q;
	logic          res_flag_q, res_run_q, res_st_valid_q;
	logic [31:0]   res_dest_q, res_st_data_q;

	logic [31:0]   regs_q [8];
	logic [2:0]    rf_idx;
	logic [31:0]   rf_rdata;

	logic [AW-1:0] mem_rd_addr, mem_wr_addr;
	logic [31:0]   mem_rdata, mem_wr_data;
	logic [3:0]    mem_wr_be;
	logic          mem_we;

	logic [31:0]   operand, addend, sum;
	logic          is_sub, alu_we, take_jump, accept, out_free, cfg_wr;

	assign uc       = uc_rom(step_q);
	assign in_ready = (uc.seq == SQ_KIND);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Register file: one read address a step
	assign rf_idx   = uc.sel_rd ? rd_q : rs_q;
	assign rf_rdata = regs_q[rf_idx];

	// ALU: one adder shared by ADD and SUB
	assign operand = mode_q ? imm_q : a_q;
	assign is_sub  = (op_q == OP_SUB);
	assign addend  = is_sub ? ~operand : operand;
	assign sum     = rf_rdata + addend + 32'(is_sub);

	always_comb begin
		alu_we = 1'b0;
		case (op_q) inside
			OP_MOV, OP_ADD, OP_SUB: alu_we = 1'b1;
			default:                alu_we = 1'b0;
		endcase
	end

	always_comb begin
		unique case (op_q)
			OP_JMP:  take_jump = 1'b1;
			OP_JE:   take_jump = flag_q;
			OP_JNE:  take_jump = !flag_q;
			default: take_jump = 1'b0;
		endcase
	end

	// Sequencer
	always_comb begin
		step_d = step_q;
		unique case (uc.seq)
			SQ_GOTO: step_d = uc.target;
			SQ_KIND: begin
				if (in_valid) begin
					unique case (kind)
						KIND_WBYTE:   step_d = S_WBYTE;
						KIND_RESTART: step_d = S_RESTART;
						KIND_EXEC:    step_d = run_q ? S_FETCH : S_DONE;
						default:      step_d = S_DONE;
					endcase
				end
			end
			SQ_OPC: begin
				unique case (op_q) inside
					OP_MOV, OP_ADD, OP_SUB, OP_CMP: step_d = S_ALU;
					OP_JMP, OP_JE, OP_JNE:          step_d = S_JUMP;
					OP_LOAD:                        step_d = S_LOAD0;
					OP_STORE:                       step_d = S_STORE;
					OP_HLT:                         step_d = S_HALT;
					default:                        step_d = S_DONE;
				endcase
			end
			SQ_WAIT_OUT: if (out_free) step_d = uc.target;
			SQ_CLEAR:    if (clr_q == '1) step_d = uc.target;
			default:     step_d = S_IDLE;
		endcase
	end

	// Memory port selection
	always_comb begin
		mem_rd_addr = pc_q;
		mem_wr_addr = pc_q;
		mem_wr_data = '0;
		mem_wr_be   = '0;
		mem_we      = 1'b0;
		case (uc.mem)
			M_RD_PC:  mem_rd_addr = pc_q;
			M_RD_PC4: mem_rd_addr = pc_q + AW'(4);
			M_RD_A:   mem_rd_addr = a_q[AW-1:0];
			M_WR_BYTE: begin
				mem_we      = 1'b1;
				mem_wr_addr = la_q;
				mem_wr_data = {24'd0, lb_q};
				mem_wr_be   = 4'b0001;
			end
			M_WR_WORD: begin
				mem_we      = 1'b1;
				mem_wr_addr = a_q[AW-1:0];
				mem_wr_data = rf_rdata;
				mem_wr_be   = 4'b1111;
			end
			M_WR_CLR: begin
				mem_we      = 1'b1;
				mem_wr_addr = {clr_q, 2'b00};
				mem_wr_be   = 4'b1111;
			end
			default: mem_we = 1'b0;
		endcase
	end

	tcis_mem u_mem (
		.clk     (clk),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rdata),
		.wr_en   (mem_we),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.wr_be   (mem_wr_be)
	);

	// Configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (paddr[PAW-1:2] == REG_START_PC) prdata = 32'(start_pc_q);
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= S_CLEAR;
			pc_q        <= '0;
			flag_q      <= 1'b0;
			run_q       <= 1'b1;
			exec_q      <= 1'b0;
			clr_q       <= '0;
			start_pc_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (cfg_wr && paddr[PAW-1:2] == REG_START_PC) start_pc_q <= pwdata[15:0];
			if (uc.mem == M_WR_CLR) clr_q <= clr_q + RW'(1);
			if (accept) exec_q <= (kind == KIND_EXEC) && run_q;

			if (uc.restart) begin
				pc_q   <= AW'(start_pc_q);
				flag_q <= 1'b0;
				run_q  <= 1'b1;
			end
			if (uc.pc_inc) pc_q <= pc_q + AW'(8);
			if (uc.jump && take_jump) pc_q <= imm_q[AW-1:0];
			if (uc.halt) run_q <= 1'b0;
			if (uc.alu) begin
				case (op_q) inside
					OP_CMP:         flag_q <= (rf_rdata == operand);
					OP_ADD, OP_SUB: flag_q <= (sum == '0);
					default:        flag_q <= flag_q;
				endcase
			end

			if (uc.seq == SQ_WAIT_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) regs_q[i] <= '0;
		end else begin
			if (uc.restart) begin
				for (int i = 0; i < 8; i++) regs_q[i] <= '0;
			end else if (uc.alu && alu_we) begin
				regs_q[rd_q] <= is_sub || op_q == OP_ADD ? sum : operand;
			end else if (uc.ld_load) begin
				regs_q[rd_q] <= mem_rdata;
			end
		end
	end

	// Datapath and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			la_q       <= AW'(load_addr);
			lb_q       <= load_byte;
			st_valid_q <= 1'b0;
			st_addr_q  <= '0;
			st_data_q  <= '0;
		end
		if (uc.ld_ir) begin
			op_q   <= mem_rdata[7:0];
			rd_q   <= mem_rdata[10:8];
			rs_q   <= mem_rdata[18:16];
			mode_q <= (mem_rdata[31:24] != 8'd0);
		end
		if (uc.ld_imm) imm_q <= mem_rdata;
		if (uc.ld_a)   a_q   <= rf_rdata;
		if (uc.store) begin
			st_valid_q <= 1'b1;
			st_addr_q  <= a_q[AW-1:0];
			st_data_q  <= rf_rdata;
		end
		if (uc.seq == SQ_WAIT_OUT && out_free) begin
			res_pc_q       <= 16'(pc_q);
			res_flag_q     <= flag_q;
			res_run_q      <= run_q;
			res_dest_q     <= exec_q ? rf_rdata : 32'd0;
			res_st_valid_q <= st_valid_q;
			res_st_addr_q  <= 16'(st_addr_q);
			res_st_data_q  <= st_data_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pc          = res_pc_q;
	assign flag        = res_flag_q;
	assign running     = res_run_q;
	assign dest_value  = res_dest_q;
	assign store_valid = res_st_valid_q;
	assign store_addr  = res_st_addr_q;
	assign store_data  = res_st_data_q;

endmodule
